/* hdl/efc_pkg.sv */
package efc_pkg;

  // frame byte counter saturates here
  localparam logic [15:0] MAX_FRAME_BYTES = 16'hffff;

  // configuration register indexes (paddr[2])
  localparam logic REG_TLS_PORT = 1'b0;
  localparam logic REG_DNS_PORT = 1'b1;
  localparam logic [15:0] TLS_PORT_RST = 16'd443;
  localparam logic [15:0] DNS_PORT_RST = 16'd53;

  // ethertypes and ip protocols
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  // frame classes
  localparam logic [2:0] CLS_ARP     = 3'd1;
  localparam logic [2:0] CLS_ICMP    = 3'd2;
  localparam logic [2:0] CLS_TCP     = 3'd3;
  localparam logic [2:0] CLS_UDP     = 3'd4;
  localparam logic [2:0] CLS_DNS     = 3'd5;
  localparam logic [2:0] CLS_TLS     = 3'd6;
  localparam logic [2:0] CLS_TLS_CONT = 3'd7;

  // sub codes
  localparam logic [2:0] SUB_NONE     = 3'd0;
  localparam logic [2:0] SUB_REQUEST  = 3'd1;
  localparam logic [2:0] SUB_REPLY    = 3'd2;
  localparam logic [2:0] SUB_TLS_CCS   = 3'd0;
  localparam logic [2:0] SUB_TLS_ALERT = 3'd1;
  localparam logic [2:0] SUB_TLS_HSHK  = 3'd2;
  localparam logic [2:0] SUB_TLS_CHELLO = 3'd3;
  localparam logic [2:0] SUB_TLS_SHELLO = 3'd4;
  localparam logic [2:0] SUB_TLS_APPDATA = 3'd5;

  // tls record types and versions
  localparam logic [7:0]  TLS_TYPE_CCS   = 8'd20;
  localparam logic [7:0]  TLS_TYPE_ALERT = 8'd21;
  localparam logic [7:0]  TLS_TYPE_APP   = 8'd23;
  localparam logic [7:0]  TLS_HS_CHELLO  = 8'd1;
  localparam logic [7:0]  TLS_HS_SHELLO  = 8'd2;
  localparam logic [15:0] TLS_VER_MIN    = 16'h0301;
  localparam logic [15:0] TLS_VER_MAX    = 16'h0304;

  // dns flags
  localparam logic [15:0] DNS_QR_OP_MASK = 16'hf800;
  localparam logic [15:0] DNS_RESPONSE   = 16'h8000;

  // icmp types
  localparam logic [7:0] ICMP_ECHO_REQ   = 8'd8;
  localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;

  // byte offsets in the frame
  localparam logic [15:0] OFF_ETYPE    = 16'd12;
  localparam logic [15:0] OFF_IP_VIHL  = 16'd14;
  localparam logic [15:0] OFF_IP_LEN   = 16'd16;
  localparam logic [15:0] OFF_ARP_OP   = 16'd20;
  localparam logic [15:0] OFF_IP_PROTO = 16'd23;
  localparam logic [15:0] OFF_ARP_SPA  = 16'd28;
  localparam logic [15:0] OFF_L4       = 16'd34;
  localparam logic [15:0] OFF_TCP_DOFF = 16'd46;
  localparam logic [15:0] OFF_TCP_FLAG = 16'd47;
  localparam logic [15:0] OFF_TCP_WIN  = 16'd48;
  localparam logic [15:0] OFF_TLS_MIN  = 16'd54;
  localparam int          L4_BYTES     = 12;

  // minimum frame lengths
  localparam logic [15:0] MIN_LEN_ARP  = 16'd42;
  localparam logic [15:0] MIN_LEN_ICMP = 16'd36;
  localparam logic [15:0] MIN_LEN_TCP  = 16'd54;
  localparam logic [15:0] MIN_LEN_UDP  = 16'd42;
  localparam logic [15:0] MIN_LEN_DNS  = 16'd46;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_in_t;

  typedef struct packed {
    logic [2:0]  frame_class;
    logic [2:0]  sub_code;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [5:0]  tcp_flag_bits;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [15:0] window_size;
    logic [15:0] payload_length;
    logic [15:0] dns_ident;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
  } frame_out_t;

  // header bytes captured for one frame; frame_len doubles as the byte offset
  typedef struct packed {
    logic [15:0]         frame_len;
    logic [15:0]         ether_kind;
    logic [7:0]          ip_proto;
    logic [3:0]          ip_hdr_words;
    logic [15:0]         ip_total_len;
    logic [11:0][7:0]    l4_bytes;
    logic [3:0]          tcp_doff;
    logic [3:0][7:0]     tls_bytes;
    logic [15:0]         arp_opcode;
    logic [31:0]         arp_sender;
    logic [5:0]          tcp_flags;
    logic [15:0]         tcp_window;
  } frame_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // start of the tls record: 34 + 4 * max(data offset, 5)
  function automatic logic [6:0] tls_rec_start(input logic [3:0] doff);
    logic [3:0] d;
    d = (doff < 4'd5) ? 4'd5 : doff;
    return 7'd34 + {1'b0, d, 2'b00};
  endfunction

endpackage

/* hdl/efc_front.sv */
module efc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  efc_pkg::frame_in_t   in_data,
  input  efc_pkg::q_status_t   q_status,
  output logic                 in_stall,
  output logic                 push,
  output efc_pkg::frame_rec_t  push_rec
);

  efc_pkg::frame_rec_t state_r, state_nxt, cap;
  logic        accept;
  logic [15:0] off;
  logic [7:0]  b;
  logic [6:0]  rs;
  logic [15:0] rs16;
  logic [15:0] rdiff;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;
  assign off      = state_r.frame_len;
  assign b        = in_data.frame_byte;
  assign rs       = efc_pkg::tls_rec_start(state_r.tcp_doff);
  assign rs16     = {9'd0, rs};
  assign rdiff    = off - rs16;

  always_comb begin
    cap = state_r;
    if (accept && off != efc_pkg::MAX_FRAME_BYTES) begin
      cap.frame_len = off + 16'd1;
      if (off == efc_pkg::OFF_ETYPE)             cap.ether_kind[15:8] = b;
      if (off == efc_pkg::OFF_ETYPE + 16'd1)     cap.ether_kind[7:0] = b;
      if (off == efc_pkg::OFF_IP_VIHL)           cap.ip_hdr_words = b[3:0];
      if (off == efc_pkg::OFF_IP_LEN)            cap.ip_total_len[15:8] = b;
      if (off == efc_pkg::OFF_IP_LEN + 16'd1)    cap.ip_total_len[7:0] = b;
      if (off == efc_pkg::OFF_ARP_OP)            cap.arp_opcode[15:8] = b;
      if (off == efc_pkg::OFF_ARP_OP + 16'd1)    cap.arp_opcode[7:0] = b;
      if (off == efc_pkg::OFF_IP_PROTO)          cap.ip_proto = b;
      if (off >= efc_pkg::OFF_ARP_SPA && off <= efc_pkg::OFF_ARP_SPA + 16'd3)
        cap.arp_sender = {state_r.arp_sender[23:0], b};
      for (int i = 0; i < efc_pkg::L4_BYTES; i++) begin
        if (off == efc_pkg::OFF_L4 + 16'(i)) cap.l4_bytes[i] = b;
      end
      if (off == efc_pkg::OFF_TCP_DOFF)          cap.tcp_doff = b[7:4];
      if (off == efc_pkg::OFF_TCP_FLAG)          cap.tcp_flags = b[5:0];
      if (off == efc_pkg::OFF_TCP_WIN)           cap.tcp_window[15:8] = b;
      if (off == efc_pkg::OFF_TCP_WIN + 16'd1)   cap.tcp_window[7:0] = b;
      if (off >= efc_pkg::OFF_TLS_MIN) begin
        // record type and version bytes, then the handshake type
        if (off >= rs16 && off <= rs16 + 16'd2) cap.tls_bytes[rdiff[1:0]] = b;
        if (off == rs16 + 16'd5)                cap.tls_bytes[3] = b;
      end
    end
  end

  assign push     = accept && in_data.last_byte;
  assign push_rec = cap;
  assign state_nxt = push ? '0 : cap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/efc_queue.sv */
module efc_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  efc_pkg::frame_rec_t  push_rec,
  input  logic                 pop,
  output efc_pkg::frame_rec_t  head_rec,
  output efc_pkg::q_status_t   q_status
);

  efc_pkg::frame_rec_t mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign q_status.full  = (count_r == 2'd2);
  assign q_status.empty = (count_r == 2'd0);
  assign do_push = push && !q_status.full;
  assign do_pop  = pop && !q_status.empty;
  assign head_rec = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* hdl/efc_back.sv */
module efc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  efc_pkg::frame_rec_t  head_rec,
  input  efc_pkg::q_status_t   q_status,
  input  logic [15:0]          tls_port,
  input  logic [15:0]          dns_port,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output efc_pkg::frame_out_t  out_data
);

  efc_pkg::frame_rec_t r;
  efc_pkg::frame_out_t res;
  efc_pkg::frame_out_t out_data_r;
  logic        out_valid_r, out_valid_nxt;
  logic        hit;
  logic [15:0] sp, dp, flags;
  logic [6:0]  rs;
  logic [15:0] rs16;
  logic [17:0] pl;
  logic [15:0] ver;
  logic [7:0]  ty;

  assign r    = head_rec;
  assign sp   = {r.l4_bytes[0], r.l4_bytes[1]};
  assign dp   = {r.l4_bytes[2], r.l4_bytes[3]};
  assign flags = {r.l4_bytes[10], r.l4_bytes[11]};
  assign rs   = efc_pkg::tls_rec_start(r.tcp_doff);
  assign rs16 = {9'd0, rs};
  assign ty   = r.tls_bytes[0];
  assign ver  = {r.tls_bytes[1], r.tls_bytes[2]};
  assign pl   = {2'b00, r.ip_total_len} - {12'd0, r.ip_hdr_words, 2'b00}
              - {12'd0, r.tcp_doff, 2'b00};

  always_comb begin
    res = '0;
    hit = 1'b0;
    if (r.ether_kind == efc_pkg::ETYPE_ARP) begin
      if (r.frame_len >= efc_pkg::MIN_LEN_ARP) begin
        hit = 1'b1;
        res.frame_class = efc_pkg::CLS_ARP;
        if (r.arp_opcode == 16'd1)      res.sub_code = efc_pkg::SUB_REQUEST;
        else if (r.arp_opcode == 16'd2) res.sub_code = efc_pkg::SUB_REPLY;
        res.src_addr = r.arp_sender;
        res.dst_addr = {r.l4_bytes[4], r.l4_bytes[5], r.l4_bytes[6], r.l4_bytes[7]};
      end
    end else if (r.ether_kind == efc_pkg::ETYPE_IPV4) begin
      if (r.ip_proto == efc_pkg::PROTO_ICMP) begin
        if (r.frame_len >= efc_pkg::MIN_LEN_ICMP) begin
          hit = 1'b1;
          res.frame_class = efc_pkg::CLS_ICMP;
          if (r.l4_bytes[1] == 8'd0 && r.l4_bytes[0] == efc_pkg::ICMP_ECHO_REQ)
            res.sub_code = efc_pkg::SUB_REQUEST;
          else if (r.l4_bytes[1] == 8'd0 && r.l4_bytes[0] == efc_pkg::ICMP_ECHO_REPLY)
            res.sub_code = efc_pkg::SUB_REPLY;
        end
      end else if (r.ip_proto == efc_pkg::PROTO_TCP) begin
        if (r.frame_len >= efc_pkg::MIN_LEN_TCP) begin
          hit = 1'b1;
          res.frame_class    = efc_pkg::CLS_TCP;
          res.src_port       = sp;
          res.dst_port       = dp;
          res.tcp_flag_bits  = r.tcp_flags;
          res.seq_number     = {r.l4_bytes[4], r.l4_bytes[5], r.l4_bytes[6], r.l4_bytes[7]};
          res.ack_number     = {r.l4_bytes[8], r.l4_bytes[9], r.l4_bytes[10], r.l4_bytes[11]};
          res.window_size    = r.tcp_window;
          // negative payload length saturates at zero
          res.payload_length = pl[17] ? 16'd0 : pl[15:0];
          if (sp == tls_port || dp == tls_port) begin
            res.frame_class = efc_pkg::CLS_TLS_CONT;
            if (r.frame_len >= rs16 + 16'd3 && ty >= efc_pkg::TLS_TYPE_CCS
                && ty <= efc_pkg::TLS_TYPE_APP && ver >= efc_pkg::TLS_VER_MIN
                && ver <= efc_pkg::TLS_VER_MAX) begin
              res.frame_class = efc_pkg::CLS_TLS;
              priority if (ty == efc_pkg::TLS_TYPE_CCS) begin
                res.sub_code = efc_pkg::SUB_TLS_CCS;
              end else if (ty == efc_pkg::TLS_TYPE_ALERT) begin
                res.sub_code = efc_pkg::SUB_TLS_ALERT;
              end else if (ty == efc_pkg::TLS_TYPE_APP) begin
                res.sub_code = efc_pkg::SUB_TLS_APPDATA;
              end else begin
                res.sub_code = efc_pkg::SUB_TLS_HSHK;
                if (r.frame_len >= rs16 + 16'd6) begin
                  if (r.tls_bytes[3] == efc_pkg::TLS_HS_CHELLO)
                    res.sub_code = efc_pkg::SUB_TLS_CHELLO;
                  else if (r.tls_bytes[3] == efc_pkg::TLS_HS_SHELLO)
                    res.sub_code = efc_pkg::SUB_TLS_SHELLO;
                end
              end
            end
          end
        end
      end else if (r.ip_proto == efc_pkg::PROTO_UDP) begin
        if (r.frame_len >= efc_pkg::MIN_LEN_UDP) begin
          res.src_port       = sp;
          res.dst_port       = dp;
          res.payload_length = {r.l4_bytes[4], r.l4_bytes[5]};
          if (sp == dns_port || dp == dns_port) begin
            if (r.frame_len >= efc_pkg::MIN_LEN_DNS) begin
              hit = 1'b1;
              res.frame_class = efc_pkg::CLS_DNS;
              if ((flags & efc_pkg::DNS_QR_OP_MASK) == 16'd0)
                res.sub_code = efc_pkg::SUB_REQUEST;
              else if ((flags & efc_pkg::DNS_QR_OP_MASK) == efc_pkg::DNS_RESPONSE)
                res.sub_code = efc_pkg::SUB_REPLY;
              res.dns_ident = {r.l4_bytes[8], r.l4_bytes[9]};
            end
          end else begin
            hit = 1'b1;
            res.frame_class = efc_pkg::CLS_UDP;
          end
        end
      end
    end
  end

  assign pop = !q_status.empty && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop)              out_valid_nxt = hit;
    else if (!out_stall)  out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (pop && hit) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hdl/ethernet_frame_classifier_core.sv */
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall   frame_in_t: frame_byte, last_byte
// out_      output     out_valid / out_stall frame_out_t: class, sub code, header fields
// apb       config     psel/penable/pwrite   tls_port at 0x0, dns_port at 0x4
//
// one byte is taken every cycle while the queue is not full; the front stage captures
// header bytes as they pass and on the last byte hands the captured header to a
// two-deep queue; the back stage classifies the queue head into the output register,
// so a result passes through the queue and then the output register
// in_stall rises only while the queue is full; frames with no class are dropped
// reset is synchronous active low and clears the byte counter, queue and out_valid
module ethernet_frame_classifier_core (
  input  logic                 clk,
  input  logic                 rst_n,
  // byte stream
  input  logic                 in_valid,
  output logic                 in_stall,
  input  efc_pkg::frame_in_t   in_data,
  // results
  output logic                 out_valid,
  input  logic                 out_stall,
  output efc_pkg::frame_out_t  out_data,
  // register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [15:0] tls_port_r, dns_port_r;
  logic        cfg_wr;

  logic                push, pop;
  efc_pkg::frame_rec_t push_rec, head_rec;
  efc_pkg::q_status_t  q_status;

  // register port: always ready, write on the access cycle
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tls_port_r <= efc_pkg::TLS_PORT_RST;
      dns_port_r <= efc_pkg::DNS_PORT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        efc_pkg::REG_TLS_PORT: tls_port_r <= pwdata[15:0];
        efc_pkg::REG_DNS_PORT: dns_port_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      efc_pkg::REG_TLS_PORT: prdata = {16'd0, tls_port_r};
      efc_pkg::REG_DNS_PORT: prdata = {16'd0, dns_port_r};
      default:               prdata = 32'd0;
    endcase
  end

  // front: byte counter and header capture
  efc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_status (q_status),
    .in_stall (in_stall),
    .push     (push),
    .push_rec (push_rec)
  );

  // captured headers waiting for classification
  efc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .q_status (q_status)
  );

  // back: classify and hold the result beat
  efc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_rec  (head_rec),
    .q_status  (q_status),
    .tls_port  (tls_port_r),
    .dns_port  (dns_port_r),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
  import efc_pkg::*;

  // run limits
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_OFF_CYCLES = 400;

  // arp opcodes as carried on the wire
  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
  localparam logic [15:0] ARP_OP_REPLY   = 16'd2;

  // kinds of frame the generator can build
  typedef enum int {
    FK_ARP, FK_ICMP, FK_TCP, FK_TLS, FK_UDP, FK_DNS, FK_NOISE
  } frame_kind_e;

  logic        clk;
  logic        rst_n = 1'b0;

  // byte stream side
  logic        in_valid = 1'b0;
  logic        in_stall;
  frame_in_t   in_data = '0;

  // result side
  logic        out_valid;
  logic        out_stall = 1'b0;
  frame_out_t  out_data;

  // register port
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ethernet_frame_classifier_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // shared bench state
  // ------------------------------------------------------------------
  frame_in_t   byte_q [$];         // beats waiting to be offered
  frame_out_t  frame_verdicts [$]; // classifications still owed by the block
  logic [7:0]  frm [$];            // scratch image of the frame being built

  logic [15:0] tls_cfg = TLS_PORT_RST;
  logic [15:0] dns_cfg = DNS_PORT_RST;

  bit          send_idle = 1'b1;   // sender inserts random gaps
  bit          take_idle = 1'b1;   // receiver inserts random stalls
  logic        hold_off = 1'b0;    // long receiver hold-off, own process
  int          phase_num = -1;
  int          bytes_sent = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          cfg_errors = 0;
  int          cycles = 0;

  // ------------------------------------------------------------------
  // header tracker: mirrors the capture logic of the block byte by byte
  // ------------------------------------------------------------------
  logic [15:0] trk_off;
  logic [15:0] trk_etype;
  logic [7:0]  trk_proto;
  logic [3:0]  trk_ihl;
  logic [15:0] trk_iplen;
  logic [7:0]  trk_l4 [12];
  logic [3:0]  trk_doff;
  logic [7:0]  trk_tls [4];
  logic [15:0] trk_arp_op;
  logic [31:0] trk_arp_spa;
  logic [5:0]  trk_flags;
  logic [15:0] trk_win;

  task automatic clear_tracking();
    trk_off     = '0;
    trk_etype   = '0;
    trk_proto   = '0;
    trk_ihl     = '0;
    trk_iplen   = '0;
    trk_l4      = '{default: 8'h00};
    trk_doff    = '0;
    trk_tls     = '{default: 8'h00};
    trk_arp_op  = '0;
    trk_arp_spa = '0;
    trk_flags   = '0;
    trk_win     = '0;
  endtask

  initial clear_tracking();

  // tls record starts after the tcp header; short data offsets count as 5
  function automatic int record_offset();
    return 34 + 4 * ((trk_doff < 4'd5) ? 5 : int'(trk_doff));
  endfunction

  // class and header fields of the frame captured so far; 0 when none
  function automatic bit classify_header(input int len, output frame_out_t v);
    int          rs;
    int          pl;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [15:0] ver;
    logic [15:0] fl;
    v  = '0;
    rs = record_offset();
    sp = {trk_l4[0], trk_l4[1]};
    dp = {trk_l4[2], trk_l4[3]};
    if (trk_etype == ETYPE_ARP) begin
      if (len < int'(MIN_LEN_ARP)) return 1'b0;
      v.frame_class = CLS_ARP;
      v.sub_code = (trk_arp_op == ARP_OP_REQUEST) ? SUB_REQUEST :
                   (trk_arp_op == ARP_OP_REPLY)   ? SUB_REPLY : SUB_NONE;
      v.src_addr = trk_arp_spa;
      v.dst_addr = {trk_l4[4], trk_l4[5], trk_l4[6], trk_l4[7]};
      return 1'b1;
    end
    if (trk_etype != ETYPE_IPV4) return 1'b0;
    case (trk_proto)
      PROTO_ICMP: begin
        if (len < int'(MIN_LEN_ICMP)) return 1'b0;
        v.frame_class = CLS_ICMP;
        if (trk_l4[1] == 8'h00 && trk_l4[0] == ICMP_ECHO_REQ) v.sub_code = SUB_REQUEST;
        else if (trk_l4[1] == 8'h00 && trk_l4[0] == ICMP_ECHO_REPLY) v.sub_code = SUB_REPLY;
        return 1'b1;
      end
      PROTO_TCP: begin
        if (len < int'(MIN_LEN_TCP)) return 1'b0;
        pl = int'(trk_iplen) - 4 * int'(trk_ihl) - 4 * int'(trk_doff);
        v.frame_class    = CLS_TCP;
        v.src_port       = sp;
        v.dst_port       = dp;
        v.tcp_flag_bits  = trk_flags;
        v.seq_number     = {trk_l4[4], trk_l4[5], trk_l4[6], trk_l4[7]};
        v.ack_number     = {trk_l4[8], trk_l4[9], trk_l4[10], trk_l4[11]};
        v.window_size    = trk_win;
        v.payload_length = (pl < 0) ? 16'h0000 : 16'(pl);
        if (sp == tls_cfg || dp == tls_cfg) begin
          ver = {trk_tls[1], trk_tls[2]};
          v.frame_class = CLS_TLS_CONT;
          // a record must start inside the frame with a known type and version
          if (len >= rs + 3 && trk_tls[0] >= TLS_TYPE_CCS && trk_tls[0] <= TLS_TYPE_APP &&
              ver >= TLS_VER_MIN && ver <= TLS_VER_MAX) begin
            v.frame_class = CLS_TLS;
            if (trk_tls[0] == TLS_TYPE_CCS) v.sub_code = SUB_TLS_CCS;
            else if (trk_tls[0] == TLS_TYPE_ALERT) v.sub_code = SUB_TLS_ALERT;
            else if (trk_tls[0] == TLS_TYPE_APP) v.sub_code = SUB_TLS_APPDATA;
            else begin
              // handshake: message type only counts when it lies inside the frame
              v.sub_code = SUB_TLS_HSHK;
              if (len >= rs + 6) begin
                if (trk_tls[3] == TLS_HS_CHELLO) v.sub_code = SUB_TLS_CHELLO;
                else if (trk_tls[3] == TLS_HS_SHELLO) v.sub_code = SUB_TLS_SHELLO;
              end
            end
          end
        end
        return 1'b1;
      end
      PROTO_UDP: begin
        if (len < int'(MIN_LEN_UDP)) return 1'b0;
        v.src_port       = sp;
        v.dst_port       = dp;
        v.payload_length = {trk_l4[4], trk_l4[5]};
        // dns wins over plain udp, and a short dns frame gives nothing at all
        if (sp == dns_cfg || dp == dns_cfg) begin
          if (len < int'(MIN_LEN_DNS)) return 1'b0;
          fl = {trk_l4[10], trk_l4[11]};
          v.frame_class = CLS_DNS;
          if ((fl & DNS_QR_OP_MASK) == 16'h0000) v.sub_code = SUB_REQUEST;
          else if ((fl & DNS_QR_OP_MASK) == DNS_RESPONSE) v.sub_code = SUB_REPLY;
          v.dns_ident = {trk_l4[8], trk_l4[9]};
          return 1'b1;
        end
        v.frame_class = CLS_UDP;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // fold one accepted beat into the tracker; on the last byte queue the verdict
  task automatic track_byte(input frame_in_t beat);
    int         off;
    int         rs;
    logic [7:0] b;
    frame_out_t v;
    off = int'(trk_off);
    b   = beat.frame_byte;
    // bytes past the counter limit are dropped until the frame ends
    if (trk_off < MAX_FRAME_BYTES) begin
      if (trk_off == OFF_ETYPE)            trk_etype[15:8] = b;
      if (trk_off == OFF_ETYPE + 16'd1)    trk_etype[7:0]  = b;
      if (trk_off == OFF_IP_VIHL)          trk_ihl         = b[3:0];
      if (trk_off == OFF_IP_LEN)           trk_iplen[15:8] = b;
      if (trk_off == OFF_IP_LEN + 16'd1)   trk_iplen[7:0]  = b;
      if (trk_off == OFF_ARP_OP)           trk_arp_op[15:8] = b;
      if (trk_off == OFF_ARP_OP + 16'd1)   trk_arp_op[7:0]  = b;
      if (trk_off == OFF_IP_PROTO)         trk_proto       = b;
      if (trk_off >= OFF_ARP_SPA && trk_off <= OFF_ARP_SPA + 16'd3)
        trk_arp_spa = {trk_arp_spa[23:0], b};
      if (off >= int'(OFF_L4) && off < int'(OFF_L4) + L4_BYTES)
        trk_l4[off - int'(OFF_L4)] = b;
      if (trk_off == OFF_TCP_DOFF)         trk_doff        = b[7:4];
      if (trk_off == OFF_TCP_FLAG)         trk_flags       = b[5:0];
      if (trk_off == OFF_TCP_WIN)          trk_win[15:8]   = b;
      if (trk_off == OFF_TCP_WIN + 16'd1)  trk_win[7:0]    = b;
      if (trk_off >= OFF_TLS_MIN) begin
        rs = record_offset();
        if (off >= rs && off <= rs + 2) trk_tls[off - rs] = b;
        if (off == rs + 5) trk_tls[3] = b;
      end
      trk_off = trk_off + 16'd1;
    end
    if (beat.last_byte) begin
      if (classify_header(int'(trk_off), v)) frame_verdicts.push_back(v);
      clear_tracking();
    end
  endtask

  // ------------------------------------------------------------------
  // frame generator
  // ------------------------------------------------------------------
  task automatic put8(input int off, input logic [7:0] val);
    if (off < frm.size()) frm[off] = val;
  endtask

  task automatic put16(input int off, input logic [15:0] val);
    put8(off, val[15:8]);
    put8(off + 1, val[7:0]);
  endtask

  // build one frame with random content and queue its beats
  // len <= 0 picks a length, sub < 0 a random variant, doff < 0 a data offset
  task automatic queue_frame(input frame_kind_e k, input int len, input int sub, input int doff);
    int          n;
    int          d;
    int          rs;
    int          s;
    int          i;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [15:0] word;
    logic [7:0]  proto;
    n = len;
    s = sub;
    d = doff;
    if (d < 0) d = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 8);
    rs = 34 + 4 * ((d < 5) ? 5 : d);
    if (n <= 0) begin
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, 60);
      else if (k == FK_TLS) n = rs + $urandom_range(0, 24);
      else n = $urandom_range(42, 100);
    end
    frm.delete();
    for (i = 0; i < n; i++) frm.push_back(8'($urandom));
    sp = 16'($urandom);
    dp = 16'($urandom);

    case (k)
      FK_ARP: begin
        if (s < 0) s = $urandom_range(0, 2);
        put16(int'(OFF_ETYPE), ETYPE_ARP);
        put16(int'(OFF_ARP_OP), (s == 0) ? ARP_OP_REQUEST :
                                (s == 1) ? ARP_OP_REPLY : 16'($urandom));
      end
      FK_NOISE: begin
        if (s < 0) s = $urandom_range(0, 3);
        if (s >= 2) begin
          // flat frames of all zeros or all ones
          for (i = 0; i < n; i++) frm[i] = (s == 3) ? 8'hff : 8'h00;
        end else if (s == 0) begin
          // unknown ethertype
          word = 16'($urandom);
          if (word == ETYPE_IPV4 || word == ETYPE_ARP) word ^= 16'h0100;
          put16(int'(OFF_ETYPE), word);
        end else begin
          // ipv4 with a protocol the block does not know
          proto = 8'($urandom);
          if (proto == PROTO_ICMP || proto == PROTO_TCP || proto == PROTO_UDP) proto ^= 8'h80;
          put16(int'(OFF_ETYPE), ETYPE_IPV4);
          put8(int'(OFF_IP_PROTO), proto);
        end
      end
      default: begin
        put16(int'(OFF_ETYPE), ETYPE_IPV4);
        put8(int'(OFF_IP_VIHL), {4'h4, ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5});
        put16(int'(OFF_IP_LEN), ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(n - 14));
        case (k)
          FK_ICMP: begin
            if (s < 0) s = $urandom_range(0, 2);
            put8(int'(OFF_IP_PROTO), PROTO_ICMP);
            put8(int'(OFF_L4), (s == 0) ? ICMP_ECHO_REQ :
                               (s == 1) ? ICMP_ECHO_REPLY : 8'($urandom));
            put8(int'(OFF_L4) + 1, (s < 2) ? 8'h00 : 8'($urandom));
          end
          FK_TCP, FK_TLS: begin
            put8(int'(OFF_IP_PROTO), PROTO_TCP);
            if (k == FK_TLS) begin
              // either port may carry the tls port
              if ($urandom_range(0, 1) == 0) sp = tls_cfg;
              else dp = tls_cfg;
            end
            put16(int'(OFF_L4), sp);
            put16(int'(OFF_L4) + 2, dp);
            put8(int'(OFF_TCP_DOFF), {4'(d), 4'($urandom)});
            if (k == FK_TLS) begin
              if (s < 0) s = $urandom_range(0, 5);
              // variants 0..3 walk the record types, 4 a random type, 5 a bad version
              if (s < 4) put8(rs, TLS_TYPE_CCS + 8'(s));
              else if (s == 4) put8(rs, 8'($urandom));
              else put8(rs, TLS_TYPE_CCS + 8'($urandom_range(0, 3)));
              if (s == 5) put16(rs + 1, 16'($urandom));
              else put16(rs + 1, 16'($urandom_range(TLS_VER_MIN, TLS_VER_MAX)));
              case ($urandom_range(0, 2))
                0:       put8(rs + 5, TLS_HS_CHELLO);
                1:       put8(rs + 5, TLS_HS_SHELLO);
                default: put8(rs + 5, 8'($urandom));
              endcase
            end
          end
          default: begin
            // plain udp or dns
            put8(int'(OFF_IP_PROTO), PROTO_UDP);
            if (k == FK_DNS) begin
              if ($urandom_range(0, 1) == 0) sp = dns_cfg;
              else dp = dns_cfg;
            end
            put16(int'(OFF_L4), sp);
            put16(int'(OFF_L4) + 2, dp);
            if (s < 0) s = $urandom_range(0, 2);
            word = 16'($urandom);
            if (s == 0) word = word & ~DNS_QR_OP_MASK;
            else if (s == 1) word = (word & ~DNS_QR_OP_MASK) | DNS_RESPONSE;
            put16(int'(OFF_L4) + 10, word);
          end
        endcase
      end
    endcase

    for (i = 0; i < n; i++) byte_q.push_back('{frame_byte: frm[i], last_byte: (i == n - 1)});
    bytes_sent += n;
  endtask

  // ------------------------------------------------------------------
  // register port
  // ------------------------------------------------------------------
  task automatic cfg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                            output logic [31:0] rd);
    // setup phase
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    // access phase, held until pready
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // write one port register with junk in the upper half, then read it back
  task automatic write_port(input logic idx, input logic [15:0] val);
    logic [31:0] rd;
    cfg_access(1'b1, {idx, 2'b00}, {16'($urandom), val}, rd);
    cfg_access(1'b0, {idx, 2'b00}, 32'h0, rd);
    if (rd[15:0] !== val) begin
      cfg_errors++;
      if (cfg_errors <= 10)
        $display("port register %0d reads %h, expected %h", idx, rd[15:0], val);
    end
    if (idx == REG_TLS_PORT) tls_cfg = val;
    else dns_cfg = val;
  endtask

  // wait until the block has nothing in flight, then let it settle
  task automatic drain();
    while (byte_q.size() != 0 || in_valid || frame_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ------------------------------------------------------------------
  // driver: one beat per item, random gap drawn per item
  // ------------------------------------------------------------------
  int send_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      // beat taken at this edge
      if (in_valid && !in_stall) track_byte(in_data);
      // a stalled beat stays put, otherwise move on
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          in_data  <= byte_q.pop_front();
          in_valid <= 1'b1;
          send_gap = send_idle ? $urandom_range(0, 9) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // monitor: compare each result beat against the oldest verdict
  // ------------------------------------------------------------------
  int take_gap = 0;

  function automatic void show_verdict(input string tag, input frame_out_t v);
    $display("%s class %0d sub %0d ports %h/%h flags %h seq %h ack %h", tag,
             v.frame_class, v.sub_code, v.src_port, v.dst_port, v.tcp_flag_bits,
             v.seq_number, v.ack_number);
    $display("%s   win %h len %h ident %h addrs %h/%h", tag,
             v.window_size, v.payload_length, v.dns_ident, v.src_addr, v.dst_addr);
  endfunction

  task automatic check_verdict(input frame_out_t got);
    frame_out_t want;
    results_seen++;
    if (frame_verdicts.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result %0d arrived with nothing expected", results_seen);
        show_verdict("  actual  ", got);
      end
    end else begin
      want = frame_verdicts.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d differs", results_seen);
          show_verdict("  expected", want);
          show_verdict("  actual  ", got);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      take_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_verdict(out_data);
        take_gap = take_idle ? $urandom_range(0, 9) : 0;
      end
      if (take_gap > 0) begin
        take_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= hold_off;
      end
    end
  end

  // long receiver hold-off in one phase so the header queue fills and the input stalls
  initial begin
    wait (phase_num == 3);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("ethernet_frame_classifier_core verification failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // stimulus sequence
  // ------------------------------------------------------------------
  initial begin
    int          p;
    int          r;
    frame_kind_e k;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames on the reset port values
    queue_frame(FK_ARP, 42, 0, -1);
    queue_frame(FK_ARP, 60, 1, -1);
    queue_frame(FK_ARP, 41, 2, -1);     // arp one byte short
    queue_frame(FK_ICMP, 36, 0, -1);
    queue_frame(FK_ICMP, 64, 1, -1);
    queue_frame(FK_ICMP, 35, 2, -1);    // icmp one byte short
    queue_frame(FK_TCP, 54, -1, 5);
    queue_frame(FK_TCP, 53, -1, 5);     // tcp one byte short
    queue_frame(FK_TCP, 80, -1, 2);     // data offset below 5
    queue_frame(FK_TLS, 80, 0, 5);
    queue_frame(FK_TLS, 80, 1, 5);
    queue_frame(FK_TLS, 80, 2, 5);
    queue_frame(FK_TLS, 80, 3, 5);
    queue_frame(FK_TLS, 80, 5, 6);      // unknown record version
    queue_frame(FK_TLS, 59, 2, 5);      // handshake type byte past the end
    queue_frame(FK_TLS, 56, 0, 5);      // record header cut short
    queue_frame(FK_TLS, 100, 2, 15);    // largest tcp header
    queue_frame(FK_UDP, 42, -1, -1);
    queue_frame(FK_UDP, 41, -1, -1);    // udp one byte short
    queue_frame(FK_DNS, 46, 0, -1);
    queue_frame(FK_DNS, 45, 0, -1);     // short dns gives nothing
    queue_frame(FK_DNS, 60, 1, -1);
    queue_frame(FK_DNS, 60, 2, -1);
    queue_frame(FK_NOISE, 64, 0, -1);   // unknown ethertype
    queue_frame(FK_NOISE, 64, 1, -1);   // unknown ip protocol
    queue_frame(FK_NOISE, 60, 2, -1);
    queue_frame(FK_NOISE, 60, 3, -1);
    queue_frame(FK_ICMP, 1, 0, -1);     // single byte frame
    drain();

    // one overlong frame past the byte counter limit, sent back to back
    send_idle = 1'b0;
    queue_frame(FK_TCP, int'(MAX_FRAME_BYTES) + 5, -1, 5);
    drain();

    // random phases, each starting with a port register setting
    bytes_sent = 0;
    p = 0;
    while (p < 6 || ((bytes_sent < 1150 || results_seen < 60) && p < 12)) begin
      phase_num = p;
      case (p % 4)
        0: begin
          write_port(REG_TLS_PORT, TLS_PORT_RST);
          write_port(REG_DNS_PORT, DNS_PORT_RST);
        end
        1: begin
          write_port(REG_TLS_PORT, 16'h0000);
          write_port(REG_DNS_PORT, 16'hffff);
        end
        2: begin
          write_port(REG_TLS_PORT, 16'hffff);
          write_port(REG_DNS_PORT, 16'h0000);
        end
        default: begin
          write_port(REG_TLS_PORT, 16'($urandom));
          write_port(REG_DNS_PORT, 16'($urandom));
        end
      endcase
      // some phases run back to back on one side or the other
      send_idle = (p % 3 != 0);
      take_idle = (p % 4 != 1);
      repeat (12) begin
        r = $urandom_range(0, 99);
        if (r < 20) k = FK_TLS;
        else if (r < 35) k = FK_TCP;
        else if (r < 50) k = FK_DNS;
        else if (r < 65) k = FK_UDP;
        else if (r < 75) k = FK_ARP;
        else if (r < 85) k = FK_ICMP;
        else k = FK_NOISE;
        queue_frame(k, 0, -1, -1);
      end
      drain();
      p++;
    end

    if (mismatches == 0 && cfg_errors == 0 && frame_verdicts.size() == 0) begin
      $display("ethernet_frame_classifier_core verification clean");
    end else begin
      $display("ethernet_frame_classifier_core verification failed");
    end
    $finish;
  end

endmodule
